### hw/rtl/ile_pkg.sv
// Shared types, codes and field layout for the indexed list engine.
package ile_pkg;

    localparam int ILE_CAPACITY    = 64;
    localparam int ILE_VALUE_WIDTH = 32;

    localparam int ACTION_W   = 3;
    localparam int POSITION_W = 7;
    localparam int ITEM_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int LENGTH_W   = 7;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ     = 3'd0,
        ACT_FRONT    = 3'd1,
        ACT_APPEND   = 3'd2,
        ACT_INSERT   = 3'd3,
        ACT_DELETE   = 3'd4
    } act_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_FRONT,
        OP_BACK,
        OP_MID,
        OP_DEL_HEAD,
        OP_DEL_MID
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ALLOC_RD,
        ST_ALLOC_WT,
        ST_PLACE,
        ST_WALK_RD,
        ST_WALK_WT,
        ST_NEXT_RD,
        ST_NEXT_WT,
        ST_DEL_WT,
        ST_LINK2,
        ST_VAL_RD,
        ST_VAL_WT,
        ST_FINISH
    } state_t;

endpackage

### hw/rtl/ile_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module ile_ram
    import ile_pkg::*;
#(
    parameter int DEPTH = ILE_CAPACITY,
    parameter int WIDTH = ILE_VALUE_WIDTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/indexed_list_engine_unit.sv
// Top level of the indexed list engine: request sequencer, list registers and stores.
//
//  Channel | Direction | Bits of tdata (lowest first)
//  --------+-----------+-------------------------------------------------------
//  s_      | in        | action[2:0], position[9:3], item_value[41:10], zero pad
//  m_      | out       | read_value[31:0], status[33:32], length[40:34], zero pad
//
// Reads, middle inserts and middle deletes walk the list from the head; the walk is
// set by the link memory, whose single read port returns one link per cycle.
// Reset (aresetn low, synchronous)
// empties the list at once; no clearing pass is needed because freed slots are
// kept on a free list threaded through the link memory. The input side takes a new
// transfer as soon as the sequencer is idle, even while a result still waits in the
// output register; a stalled result only holds the sequencer at its final step.
module indexed_list_engine_unit
    import ile_pkg::*;
#(
    parameter int CAPACITY    = ILE_CAPACITY,
    parameter int VALUE_WIDTH = ILE_VALUE_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // action, position, item_value, zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // read_value, status, length, zero pad
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    // Comparison width wide enough for both the position field and the count.
    localparam int PW = ((CW > POSITION_W) ? CW : POSITION_W) + 1;

    // Sequencer and list registers.
    state_t                  state_reg,  state_next;
    op_t                     op_reg,     op_next;
    act_t                    act_reg,    act_next;
    logic [POSITION_W-1:0]   pos_reg,    pos_next;
    logic signed [ITEM_W-1:0] val_reg,   val_next;
    logic [CW-1:0]           count_reg,  count_next;
    logic [CW-1:0]           hwm_reg,    hwm_next;
    logic [CW-1:0]           fcnt_reg,   fcnt_next;
    logic [AW-1:0]           fhead_reg,  fhead_next;
    logic [AW-1:0]           head_reg,   head_next;
    logic [AW-1:0]           tail_reg,   tail_next;
    logic [AW-1:0]           cur_reg,    cur_next;
    logic [AW-1:0]           slot_reg,   slot_next;
    logic [CW-1:0]           steps_reg,  steps_next;
    logic [ITEM_W-1:0]       rv_reg,     rv_next;
    stat_t                   stat_reg,   stat_next;

    // Output register.
    logic                    m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]    m_data_reg,  m_data_next;

    // Memory ports.
    logic                    lk_we;
    logic [AW-1:0]           lk_waddr, lk_wdata, lk_raddr, lk_q;
    logic                    vl_we;
    logic [VALUE_WIDTH-1:0]  vl_wdata, vl_q;

    logic signed [63:0]          in_ext;
    logic signed [VALUE_WIDTH-1:0] vq_s;
    logic signed [63:0]          out_ext;
    logic [PW-1:0]               pos_w, count_w;

    // The value link store: one link per slot, also threading the free list.
    ile_ram #(.DEPTH(CAPACITY), .WIDTH(AW)) u_link_ram (
        .aclk  (aclk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .raddr (lk_raddr),
        .rdata (lk_q)
    );

    // The value store is written only when a slot is filled and read at the end of a read walk.
    ile_ram #(.DEPTH(CAPACITY), .WIDTH(VALUE_WIDTH)) u_value_ram (
        .aclk  (aclk),
        .we    (vl_we),
        .waddr (slot_reg),
        .wdata (vl_wdata),
        .raddr (cur_reg),
        .rdata (vl_q)
    );

    // Values are stored in VALUE_WIDTH bits and sign-extended back to the field width.
    assign in_ext   = 64'(val_reg);
    assign vl_wdata = in_ext[VALUE_WIDTH-1:0];
    assign vq_s     = vl_q;
    assign out_ext  = 64'(vq_s);

    assign pos_w   = PW'(pos_reg);
    assign count_w = PW'(count_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            hwm_reg     <= '0;
            fcnt_reg    <= '0;
            fhead_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            hwm_reg     <= hwm_next;
            fcnt_reg    <= fcnt_next;
            fhead_reg   <= fhead_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request payload and walk registers need no reset.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        act_reg    <= act_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        cur_reg    <= cur_next;
        slot_reg   <= slot_next;
        steps_reg  <= steps_next;
        rv_reg     <= rv_next;
        stat_reg   <= stat_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        act_next     = act_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        hwm_next     = hwm_reg;
        fcnt_next    = fcnt_reg;
        fhead_next   = fhead_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_next     = cur_reg;
        slot_next    = slot_reg;
        steps_next   = steps_reg;
        rv_next      = rv_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        lk_we        = 1'b0;
        lk_waddr     = slot_reg;
        lk_wdata     = head_reg;
        lk_raddr     = cur_reg;
        vl_we        = 1'b0;

        // A waiting result leaves once the downstream side takes it.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next   = act_t'(s_tdata[ACTION_W-1:0]);
                    pos_next   = s_tdata[ACTION_W +: POSITION_W];
                    val_next   = s_tdata[ACTION_W + POSITION_W +: ITEM_W];
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE: begin
                rv_next    = '1;
                stat_next  = STAT_DONE;
                cur_next   = head_reg;
                state_next = ST_FINISH;
                case (act_reg)
                    ACT_READ: begin
                        if (pos_w < count_w) begin
                            op_next    = OP_READ;
                            steps_next = CW'(pos_reg);
                            state_next = ST_WALK_RD;
                        end else begin
                            stat_next = STAT_IGNORED;
                        end
                    end
                    ACT_FRONT, ACT_APPEND, ACT_INSERT: begin
                        if (act_reg == ACT_INSERT && pos_w > count_w) begin
                            stat_next = STAT_IGNORED;
                        end else if (count_reg >= CW'(CAPACITY)) begin
                            stat_next = STAT_FULL;
                        end else begin
                            state_next = ST_ALLOC_RD;
                            if (act_reg == ACT_FRONT) begin
                                op_next = OP_FRONT;
                            end else if (act_reg == ACT_APPEND) begin
                                op_next = OP_BACK;
                            end else if (pos_reg == '0) begin
                                op_next = OP_FRONT;
                            end else if (pos_w == count_w) begin
                                op_next = OP_BACK;
                            end else begin
                                op_next = OP_MID;
                            end
                        end
                    end
                    ACT_DELETE: begin
                        if (pos_w >= count_w) begin
                            stat_next = STAT_IGNORED;
                        end else if (pos_reg == '0) begin
                            op_next    = OP_DEL_HEAD;
                            state_next = ST_NEXT_RD;
                        end else begin
                            op_next    = OP_DEL_MID;
                            steps_next = CW'(pos_reg) - CW'(1);
                            state_next = ST_WALK_RD;
                        end
                    end
                    default: begin
                        stat_next = STAT_IGNORED;
                    end
                endcase
            end

            // Take a recycled slot from the free list, or a slot never used before.
            ST_ALLOC_RD: begin
                if (fcnt_reg != '0) begin
                    lk_raddr   = fhead_reg;
                    state_next = ST_ALLOC_WT;
                end else begin
                    slot_next  = hwm_reg[AW-1:0];
                    hwm_next   = hwm_reg + CW'(1);
                    state_next = ST_PLACE;
                end
            end

            ST_ALLOC_WT: begin
                slot_next  = fhead_reg;
                fhead_next = lk_q;
                fcnt_next  = fcnt_reg - CW'(1);
                state_next = ST_PLACE;
            end

            ST_PLACE: begin
                vl_we = 1'b1;
                case (op_reg)
                    OP_FRONT: begin
                        lk_we      = 1'b1;
                        lk_waddr   = slot_reg;
                        lk_wdata   = head_reg;
                        head_next  = slot_reg;
                        if (count_reg == '0) begin
                            tail_next = slot_reg;
                        end
                        count_next = count_reg + CW'(1);
                        state_next = ST_FINISH;
                    end
                    OP_BACK: begin
                        if (count_reg != '0) begin
                            lk_we    = 1'b1;
                            lk_waddr = tail_reg;
                            lk_wdata = slot_reg;
                        end else begin
                            head_next = slot_reg;
                        end
                        tail_next  = slot_reg;
                        count_next = count_reg + CW'(1);
                        state_next = ST_FINISH;
                    end
                    default: begin
                        // Middle insert: find the entry in front of the new one.
                        cur_next   = head_reg;
                        steps_next = CW'(pos_reg) - CW'(1);
                        state_next = ST_WALK_RD;
                    end
                endcase
            end

            ST_WALK_RD: begin
                if (steps_reg == '0) begin
                    state_next = (op_reg == OP_READ) ? ST_VAL_RD : ST_NEXT_RD;
                end else begin
                    lk_raddr   = cur_reg;
                    state_next = ST_WALK_WT;
                end
            end

            // One link per cycle: the returned link addresses the next read directly.
            ST_WALK_WT: begin
                cur_next   = lk_q;
                steps_next = steps_reg - CW'(1);
                if (steps_reg == CW'(1)) begin
                    state_next = (op_reg == OP_READ) ? ST_VAL_RD : ST_NEXT_RD;
                end else begin
                    lk_raddr = lk_q;
                end
            end

            ST_NEXT_RD: begin
                lk_raddr   = cur_reg;
                state_next = ST_NEXT_WT;
            end

            ST_NEXT_WT: begin
                case (op_reg)
                    OP_MID: begin
                        lk_we      = 1'b1;
                        lk_waddr   = slot_reg;
                        lk_wdata   = lk_q;
                        state_next = ST_LINK2;
                    end
                    OP_DEL_HEAD: begin
                        head_next  = lk_q;
                        lk_we      = 1'b1;
                        lk_waddr   = cur_reg;
                        lk_wdata   = fhead_reg;
                        fhead_next = cur_reg;
                        fcnt_next  = fcnt_reg + CW'(1);
                        count_next = count_reg - CW'(1);
                        state_next = ST_FINISH;
                    end
                    default: begin
                        // Middle delete: the link read here names the victim.
                        slot_next  = lk_q;
                        lk_raddr   = lk_q;
                        state_next = ST_DEL_WT;
                    end
                endcase
            end

            ST_DEL_WT: begin
                lk_we      = 1'b1;
                lk_waddr   = cur_reg;
                lk_wdata   = lk_q;
                state_next = ST_LINK2;
            end

            ST_LINK2: begin
                lk_we = 1'b1;
                if (op_reg == OP_MID) begin
                    lk_waddr   = cur_reg;
                    lk_wdata   = slot_reg;
                    count_next = count_reg + CW'(1);
                end else begin
                    // Return the victim to the free list.
                    lk_waddr   = slot_reg;
                    lk_wdata   = fhead_reg;
                    fhead_next = slot_reg;
                    fcnt_next  = fcnt_reg + CW'(1);
                    count_next = count_reg - CW'(1);
                    if (pos_w + PW'(1) == count_w) begin
                        tail_next = cur_reg;
                    end
                end
                state_next = ST_FINISH;
            end

            ST_VAL_RD: begin
                state_next = ST_VAL_WT;
            end

            ST_VAL_WT: begin
                rv_next    = out_ext[ITEM_W-1:0];
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({LENGTH_W'(count_reg), stat_reg, rv_reg});
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
